// ===== sv/rpfs_pkg.sv =====
// rpfs_pkg: constants, register codes and control/status types for the
// level-run frame sync decoder; no dependencies
package rpfs_pkg;

    localparam int FRAME_BITS_DEF = 96;

    localparam int LEVEL_W  = 1;
    localparam int DUR_W    = 16;
    localparam int PERIOD_W = 10;
    localparam int SKEW_W   = 9;
    localparam int DATA_W   = 64;
    localparam int PRE_W    = 32;

    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 10;

    localparam logic [CFG_IDX_W-1:0] CFG_BIT_PERIOD = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_SKEW       = CFG_IDX_W'(1);

    localparam logic [PERIOD_W-1:0] PERIOD_RESET = PERIOD_W'(255);
    localparam logic [PERIOD_W-1:0] PERIOD_MIN   = PERIOD_W'(16);
    localparam logic [SKEW_W-1:0]   SKEW_RESET   = SKEW_W'(120);

    localparam logic [PRE_W-1:0] PREAMBLE = 32'h4944_544B;

    // dividend is the duration, raw or skew-corrected, plus half a period
    localparam int DVD_W     = DUR_W + 1;
    localparam int DIV_CNT_W = $clog2(DVD_W + 1);

    localparam int SHIFT_REGS = 4;
    localparam int SEL_W      = 2;

    typedef struct packed {
        logic             load_item;
        logic             div_start;
        logic             div_adj;
        logic             div_step;
        logic             push_load;
        logic             push;
        logic [SEL_W-1:0] sel;
        logic             out_load;
        logic             out_hit;
    } rpfs_cmd_t;

    typedef struct packed {
        logic short_run;
        logic div_done;
        logic count_ok;
        logic push_last;
        logic push_match;
        logic out_free;
    } rpfs_stat_t;

endpackage

// ===== sv/rpfs_if.sv =====
// rpfs_if: valid/ready channel interfaces for runs, results and config writes
// depends on rpfs_pkg
interface rpfs_in_if import rpfs_pkg::*; ();
    logic             valid;
    logic             ready;
    logic             run_level;
    logic [DUR_W-1:0] duration_us;

    modport source (output valid, output run_level, output duration_us, input ready);
    modport sink (input valid, input run_level, input duration_us, output ready);
endinterface

interface rpfs_out_if import rpfs_pkg::*; ();
    logic              valid;
    logic              ready;
    logic              detected;
    logic [DATA_W-1:0] card_data;

    modport source (output valid, output detected, output card_data, input ready);
    modport sink (input valid, input detected, input card_data, output ready);
endinterface

interface rpfs_cfg_if import rpfs_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

// ===== sv/rpfs_ctrl.sv =====
// rpfs_ctrl: sequencer for one run (range check, divisions, bit pushes, result)
// depends on rpfs_pkg
module rpfs_ctrl
    import rpfs_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  rpfs_stat_t stat,
    output rpfs_cmd_t  cmd
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_CHECK = 3'd1;
    localparam logic [2:0] S_DIV   = 3'd2;
    localparam logic [2:0] S_PUSH  = 3'd3;
    localparam logic [2:0] S_DONE  = 3'd4;

    logic [2:0]       state_reg, state_next;
    logic [SEL_W-1:0] sel_reg, sel_next;
    logic             hit_reg, hit_next;
    logic             advance;

    assign in_ready = (state_reg == S_IDLE);

    always_comb
    begin
        state_next = state_reg;
        sel_next   = sel_reg;
        hit_next   = hit_reg;
        advance    = 1'b0;
        cmd        = '0;
        cmd.sel    = sel_reg;
        cmd.out_hit = hit_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load_item = 1'b1;
                    state_next    = S_CHECK;
                end
            end
            S_CHECK:
            begin
                sel_next = '0;
                hit_next = 1'b0;
                if (stat.short_run)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    cmd.div_start = 1'b1;
                    state_next    = S_DIV;
                end
            end
            S_DIV:
            begin
                if (!stat.div_done)
                begin
                    cmd.div_step = 1'b1;
                end
                else if (stat.count_ok)
                begin
                    cmd.push_load = 1'b1;
                    state_next    = S_PUSH;
                end
                else
                begin
                    advance = 1'b1;
                end
            end
            S_PUSH:
            begin
                cmd.push = 1'b1;
                if (stat.push_match)
                begin
                    hit_next   = 1'b1;
                    state_next = S_DONE;
                end
                else if (stat.push_last)
                begin
                    advance = 1'b1;
                end
            end
            S_DONE:
            begin
                if (stat.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // move on to the next shift register; skewed pair needs a new count
        if (advance)
        begin
            if (sel_reg == SEL_W'(SHIFT_REGS - 1))
            begin
                state_next = S_DONE;
            end
            else
            begin
                sel_next   = sel_reg + SEL_W'(1);
                state_next = S_DIV;
                if (sel_reg == SEL_W'(1))
                begin
                    cmd.div_start = 1'b1;
                    cmd.div_adj   = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            sel_reg   <= '0;
            hit_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            sel_reg   <= sel_next;
            hit_reg   <= hit_next;
        end
    end

endmodule

// ===== sv/rpfs_datapath.sv =====
// rpfs_datapath: config registers, run latch, serial divider, four shift
// registers and output word register; depends on rpfs_pkg
module rpfs_datapath
    import rpfs_pkg::*;
#(
    parameter int FRAME_BITS = FRAME_BITS_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  run_level,
    input  logic [DUR_W-1:0]      duration_us,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic                  detected,
    output logic [DATA_W-1:0]     card_data,
    input  rpfs_cmd_t             cmd,
    output rpfs_stat_t            stat
);

    localparam int CNT_W = $clog2(FRAME_BITS);

    logic [PERIOD_W-1:0]   cfg_period_reg;
    logic [SKEW_W-1:0]     cfg_skew_reg;

    logic                  level_reg;
    logic [DUR_W-1:0]      dur_reg;
    logic [PERIOD_W-1:0]   period_reg;
    logic [DVD_W-1:0]      adj_reg;

    logic [DVD_W-1:0]      dvd_reg, dvd_next;
    logic [PERIOD_W-1:0]   rem_reg, rem_next;
    logic [DIV_CNT_W-1:0]  div_cnt_reg, div_cnt_next;
    logic [CNT_W-1:0]      left_reg, left_next;

    logic [FRAME_BITS-1:0] sh_reg [SHIFT_REGS];
    logic [FRAME_BITS-1:0] sh_cur;

    logic                  out_valid_reg, out_valid_next;
    logic                  out_det_reg;
    logic [DATA_W-1:0]     out_data_reg;

    logic [DVD_W-1:0]      adj_in;
    logic [DVD_W-1:0]      dvd_src;
    logic [PERIOD_W:0]     trial;
    logic                  trial_ge;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_period_reg <= PERIOD_RESET;
            cfg_skew_reg   <= SKEW_RESET;
        end
        else if (cfg_valid)
        begin
            if (cfg_index == CFG_BIT_PERIOD)
            begin
                cfg_period_reg <= cfg_data[PERIOD_W-1:0];
            end
            else if (cfg_index == CFG_SKEW)
            begin
                cfg_skew_reg <= cfg_data[SKEW_W-1:0];
            end
        end
    end

    // skew-corrected duration
    always_comb
    begin
        if (run_level)
        begin
            adj_in = {1'b0, duration_us} + DVD_W'(cfg_skew_reg);
        end
        else if (duration_us > DUR_W'(cfg_skew_reg))
        begin
            adj_in = {1'b0, duration_us - DUR_W'(cfg_skew_reg)};
        end
        else
        begin
            adj_in = {1'b0, duration_us};
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_item)
        begin
            level_reg  <= run_level;
            dur_reg    <= duration_us;
            period_reg <= (cfg_period_reg < PERIOD_MIN) ? PERIOD_MIN : cfg_period_reg;
            adj_reg    <= adj_in;
        end
    end

    // restoring divider, one quotient bit a cycle
    assign dvd_src  = (cmd.div_adj ? adj_reg : {1'b0, dur_reg})
                    + DVD_W'(period_reg >> 1);
    assign trial    = {rem_reg, dvd_reg[DVD_W-1]};
    assign trial_ge = (trial >= {1'b0, period_reg});

    always_comb
    begin
        dvd_next     = dvd_reg;
        rem_next     = rem_reg;
        div_cnt_next = div_cnt_reg;
        left_next    = left_reg;
        if (cmd.div_start)
        begin
            dvd_next     = dvd_src;
            rem_next     = '0;
            div_cnt_next = DIV_CNT_W'(DVD_W);
        end
        else if (cmd.div_step)
        begin
            dvd_next     = {dvd_reg[DVD_W-2:0], trial_ge};
            rem_next     = PERIOD_W'(trial_ge ? trial - {1'b0, period_reg} : trial);
            div_cnt_next = div_cnt_reg - DIV_CNT_W'(1);
        end
        if (cmd.push_load)
        begin
            left_next = dvd_reg[CNT_W-1:0];
        end
        else if (cmd.push)
        begin
            left_next = left_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            div_cnt_reg <= '0;
        end
        else
        begin
            div_cnt_reg <= div_cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dvd_reg  <= dvd_next;
        rem_reg  <= rem_next;
        left_reg <= left_next;
    end

    assign sh_cur = sh_reg[cmd.sel];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < SHIFT_REGS; i++)
            begin
                sh_reg[i] <= '0;
            end
        end
        else if (cmd.push)
        begin
            sh_reg[cmd.sel] <= {sh_cur[FRAME_BITS-2:0], level_reg ^ cmd.sel[0]};
        end
    end

    // output word register
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            out_det_reg  <= cmd.out_hit;
            out_data_reg <= cmd.out_hit ? sh_cur[FRAME_BITS-PRE_W-1 -: DATA_W] : '0;
        end
    end

    assign out_valid = out_valid_reg;
    assign detected  = out_det_reg;
    assign card_data = out_data_reg;

    assign stat.short_run  = ({1'b0, dur_reg} <= DVD_W'(period_reg >> 1));
    assign stat.div_done   = (div_cnt_reg == '0);
    assign stat.count_ok   = (dvd_reg != '0) && (dvd_reg < DVD_W'(FRAME_BITS));
    assign stat.push_last  = (left_reg == CNT_W'(1));
    assign stat.push_match = (sh_cur[FRAME_BITS-2 -: PRE_W] == PREAMBLE);
    assign stat.out_free   = !out_valid_reg || out_ready;

endmodule

// ===== sv/rfid_pulse_frame_sync_decoder.sv =====
// rfid_pulse_frame_sync_decoder: top level, controller plus datapath
// depends on rpfs_pkg, rpfs_if, rpfs_ctrl, rpfs_datapath
//
//   channel  | dir | word
//   in_ch    | in  | run_level, duration_us
//   out_ch   | out | detected, card_data
//   cfg_ch   | in  | index (0 bit_period_us, 1 skew_us), data
//
// a short run goes straight to the result; otherwise a run takes the divisions and
// up to 4 * (FRAME_BITS - 1) pushes, one bit a cycle; the serial
// divider runs for the raw and again for the skewed count
// reset clears config to defaults and all shift registers to zero
// a waiting result holds the next one back, the next run is still accepted
module rfid_pulse_frame_sync_decoder
    import rpfs_pkg::*;
#(
    parameter int FRAME_BITS = FRAME_BITS_DEF
)
(
    input  logic   clk,
    input  logic   rst_n,
    rpfs_in_if.sink    in_ch,
    rpfs_out_if.source out_ch,
    rpfs_cfg_if.sink   cfg_ch
);

    rpfs_cmd_t  cmd;
    rpfs_stat_t stat;

    rpfs_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_ch.valid),
        .in_ready (in_ch.ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    rpfs_datapath #(
        .FRAME_BITS (FRAME_BITS)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .run_level   (in_ch.run_level),
        .duration_us (in_ch.duration_us),
        .cfg_valid   (cfg_ch.valid),
        .cfg_ready   (cfg_ch.ready),
        .cfg_index   (cfg_ch.index),
        .cfg_data    (cfg_ch.data),
        .out_valid   (out_ch.valid),
        .out_ready   (out_ch.ready),
        .detected    (out_ch.detected),
        .card_data   (out_ch.card_data),
        .cmd         (cmd),
        .stat        (stat)
    );

endmodule
